>>> rtl/core/nearest_palette_color_mapper_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest palette color mapper
// Shared helpers that wrap one concurrent assertion each.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_MAPPER_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled while dis_expr is true.
`define NPPC_ASSERT_SAME(label, clk_sig, dis_expr, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (dis_expr) (ante) |-> (cons)) \
    else $error("nppc assertion failed");

// Next-cycle implication, disabled while dis_expr is true.
`define NPPC_ASSERT_NEXT(label, clk_sig, dis_expr, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (dis_expr) (ante) |=> (cons)) \
    else $error("nppc assertion failed");

`endif

>>> rtl/core/nppc_pkg.sv
// ----------------------------------------------------------------------------
// Nearest palette color mapper package
// Types and fixed constants shared by the mapper's modules.
// ----------------------------------------------------------------------------
package nppc_pkg;

  // Width of one color channel and of the beat index field.
  localparam int CHAN_W     = 8;
  localparam int INDEX_W    = 8;
  localparam int COLOR_W    = 3 * CHAN_W;
  // Slots that an index field can reach.
  localparam int INDEX_SPAN = 256;
  // Squared channel difference and full squared distance widths.
  localparam int SQ_W       = 2 * CHAN_W;
  localparam int DIST_W     = SQ_W + 2;
  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Request kinds carried on in_tuser.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_MAP   = 1'b1
  } op_t;

  // One classified request as it sits in the queue.
  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] color;
  } task_t;

  // Back part sequencer states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_FLUSH,
    B_DONE
  } back_state_t;

endpackage

>>> rtl/core/nppc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nppc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/nppc_front.sv
// ----------------------------------------------------------------------------
// Nearest palette color mapper front part
// Accepts input beats, drops writes beyond the palette and stages the rest.
// ----------------------------------------------------------------------------
module nppc_front
  import nppc_pkg::*;
#(
  parameter int SPAN = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,
  input  logic [31:0] in_tdata,
  output logic        push_valid,
  input  logic        push_ready,
  output task_t       push_task
);

  logic  hold_valid_r, hold_valid_nxt;
  task_t hold_r, hold_nxt;
  task_t decoded;
  logic  keep;
  logic  accept;

  // Decode the beat into a request.
  always_comb begin
    decoded.op    = op_t'(in_tuser);
    decoded.index = in_tdata[INDEX_W-1:0];
    decoded.color = in_tdata[INDEX_W +: COLOR_W];
  end

  // A write to a slot outside the palette has no effect at all.
  assign keep = (decoded.op == OP_MAP) ||
                ({1'b0, decoded.index} < (INDEX_W+1)'(SPAN));

  assign in_tready  = !hold_valid_r || push_ready;
  assign accept     = in_tvalid && in_tready;
  assign push_valid = hold_valid_r;
  assign push_task  = hold_r;

  // Staging register next state.
  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    if (hold_valid_r && push_ready) begin
      hold_valid_nxt = 1'b0;
    end
    if (accept && keep) begin
      hold_valid_nxt = 1'b1;
      hold_nxt       = decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

>>> rtl/core/nppc_fifo.sv
// ----------------------------------------------------------------------------
// Nearest palette color mapper request queue
// Short queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module nppc_fifo
  import nppc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  task_t push_task,
  output logic  pop_valid,
  input  logic  pop_ready,
  output task_t pop_task
);

  task_t             entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_task   = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_task;
    end
  end

endmodule

>>> rtl/core/nppc_back.sv
// ----------------------------------------------------------------------------
// Nearest palette color mapper back part
// Executes palette writes and runs the nearest-color search over the store.
// ----------------------------------------------------------------------------
module nppc_back
  import nppc_pkg::*;
#(
  parameter int SPAN = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               task_valid,
  output logic               task_ready,
  input  task_t              task_in,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [INDEX_W-1:0] res_index,
  output logic [COLOR_W-1:0] res_color
);

  localparam int IDXW = $clog2(SPAN);

  back_state_t state_r, state_nxt;

  // Control outputs of the sequencer.
  logic ram_we, ram_re, start_map, load_out;

  // Scan counter and captured pixel.
  logic [IDXW-1:0]    cnt_r, cnt_nxt;
  logic [COLOR_W-1:0] pixel_r;

  // Entry valid bits; an entry never written reads as black.
  logic [SPAN-1:0] vld_r;

  // Pipeline stage 1: memory read data is valid.
  logic               p1_vld_r;
  logic [IDXW-1:0]    p1_idx_r;
  logic               p1_hit_r;
  logic [COLOR_W-1:0] ram_rdata;
  logic [COLOR_W-1:0] p1_color;

  // Pipeline stage 2: squared channel differences.
  logic               p2_vld_r;
  logic [IDXW-1:0]    p2_idx_r;
  logic [COLOR_W-1:0] p2_color_r;
  logic [SQ_W-1:0]    p2_sq_r [3];
  logic [CHAN_W-1:0]  diff [3];
  logic [DIST_W-1:0]  cand_dist;
  logic               better;

  // Best candidate so far.
  logic [DIST_W-1:0]  best_dist_r;
  logic [IDXW-1:0]    best_idx_r;
  logic [COLOR_W-1:0] best_color_r;

  // Output register.
  logic               res_valid_r, res_valid_nxt;
  logic [INDEX_W-1:0] res_index_r;
  logic [COLOR_W-1:0] res_color_r;

  nppc_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(SPAN)
  ) u_palette (
    .clk  (clk),
    .we   (ram_we),
    .waddr(task_in.index[IDXW-1:0]),
    .wdata(task_in.color),
    .re   (ram_re),
    .raddr(cnt_r),
    .rdata(ram_rdata)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (task_valid && task_in.op == OP_MAP) begin
          state_nxt = B_SCAN;
        end
      end
      B_SCAN: begin
        if (cnt_r == IDXW'(SPAN - 1)) begin
          state_nxt = B_FLUSH;
        end
      end
      B_FLUSH: begin
        if (!p1_vld_r && !p2_vld_r) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!res_valid_r || res_ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    task_ready = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    start_map  = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      B_IDLE: begin
        task_ready = 1'b1;
        ram_we     = task_valid && (task_in.op == OP_WRITE);
        start_map  = task_valid && (task_in.op == OP_MAP);
      end
      B_SCAN: begin
        ram_re = 1'b1;
      end
      B_FLUSH: begin
      end
      B_DONE: begin
        load_out = !res_valid_r || res_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Scan counter and pixel capture.
  assign cnt_nxt = start_map ? '0 : (ram_re ? cnt_r + 1'b1 : cnt_r);

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (start_map) begin
      pixel_r <= task_in.color;
    end
  end

  // Valid bits are set by writes and cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[task_in.index[IDXW-1:0]] <= 1'b1;
    end
  end

  // Stage 1 tracks the entry whose read is in flight.
  always_ff @(posedge clk) begin
    p1_idx_r <= cnt_r;
    p1_hit_r <= vld_r[cnt_r];
  end

  assign p1_color = p1_hit_r ? ram_rdata : '0;

  // Absolute channel differences against the pixel.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (pixel_r[c*CHAN_W +: CHAN_W] > p1_color[c*CHAN_W +: CHAN_W]) begin
        diff[c] = pixel_r[c*CHAN_W +: CHAN_W] - p1_color[c*CHAN_W +: CHAN_W];
      end else begin
        diff[c] = p1_color[c*CHAN_W +: CHAN_W] - pixel_r[c*CHAN_W +: CHAN_W];
      end
    end
  end

  // Stage 2 holds the squared differences.
  always_ff @(posedge clk) begin
    p2_idx_r   <= p1_idx_r;
    p2_color_r <= p1_color;
    for (int c = 0; c < 3; c++) begin
      p2_sq_r[c] <= diff[c] * diff[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= ram_re;
      p2_vld_r <= p1_vld_r;
    end
  end

  // Sum and compare; the first entry always seeds the search.
  assign cand_dist = DIST_W'(p2_sq_r[0]) + DIST_W'(p2_sq_r[1]) + DIST_W'(p2_sq_r[2]);
  assign better    = (p2_idx_r == '0) || (cand_dist < best_dist_r);

  always_ff @(posedge clk) begin
    if (p2_vld_r && better) begin
      best_dist_r  <= cand_dist;
      best_idx_r   <= p2_idx_r;
      best_color_r <= p2_color_r;
    end
  end

  // Output register holds the result until it is taken.
  always_comb begin
    res_valid_nxt = res_valid_r;
    if (res_valid_r && res_ready) begin
      res_valid_nxt = 1'b0;
    end
    if (load_out) begin
      res_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_index_r <= INDEX_W'(best_idx_r);
      res_color_r <= best_color_r;
    end
  end

  assign res_valid = res_valid_r;
  assign res_index = res_index_r;
  assign res_color = res_color_r;

endmodule

>>> rtl/core/nearest_palette_color_mapper.sv
// A write beat stores one color in the palette and gives no result; a map beat
// gives the index and color of the nearest palette entry by squared Euclidean
// distance, the lowest index winning a tie. The search reads the palette
// memory one entry per cycle through its single read port, scanning S entries,
// where S is the smaller of PALETTE_ENTRIES and 256; a write is done there
// straight from the idle state and gives no search. A queue
// lets new beats be accepted while a search runs, and the palette reads as all
// black after reset with no clearing pass.
// ----------------------------------------------------------------------------
// Nearest palette color mapper
// Top level: front part, request queue and back search engine.
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper
  import nppc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // req_type
  input  logic [31:0] in_tdata,   // entry_index, red, green, blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // match_index, mapped_red, mapped_green, mapped_blue
);

  localparam int SPAN = (PALETTE_ENTRIES < INDEX_SPAN) ? PALETTE_ENTRIES : INDEX_SPAN;

  logic               push_valid, push_ready;
  task_t              push_task;
  logic               pop_valid, pop_ready;
  task_t              pop_task;
  logic [INDEX_W-1:0] res_index;
  logic [COLOR_W-1:0] res_color;

  nppc_front #(
    .SPAN(SPAN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_task (push_task)
  );

  nppc_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_task (push_task),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_task  (pop_task)
  );

  nppc_back #(
    .SPAN(SPAN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .task_valid(pop_valid),
    .task_ready(pop_ready),
    .task_in   (pop_task),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_index (res_index),
    .res_color (res_color)
  );

  // Result beat packing, index in the low byte.
  assign out_tdata = {res_color, res_index};

endmodule

>>> rtl/core/nppc_checker.sv
// ----------------------------------------------------------------------------
// Nearest palette color mapper port checker
// Watches the top-level ports for output channel and result rules.
// ----------------------------------------------------------------------------
`include "nearest_palette_color_mapper_assert.svh"

module nppc_checker #(
  parameter int PALETTE_ENTRIES = 256
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  logic out_stall;

  assign out_stall = out_tvalid && !out_tready;

  // A stalled result beat stays offered.
  `NPPC_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_stall, out_tvalid)

  // A stalled result beat keeps its data.
  `NPPC_ASSERT_NEXT(a_out_stable, clk, !rst_n, out_stall, $stable(out_tdata))

  // Reset leaves no result pending.
  `NPPC_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_tvalid)

  // A result always names a slot inside the palette.
  `NPPC_ASSERT_SAME(a_index_range, clk, !rst_n, out_tvalid,
                    (PALETTE_ENTRIES >= 256) || (out_tdata[7:0] < PALETTE_ENTRIES))

endmodule

bind nearest_palette_color_mapper nppc_checker #(
  .PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_checker (.*);
